>>> rtl/gdfs_pkg.sv
// ----------------------------------------------------------------------------
// gdfs_pkg
// Shared codes, widths and the command/status bundles passed between the
// depth-first search controller and its datapath.
// ----------------------------------------------------------------------------
package gdfs_pkg;

	// field widths fixed by the interface
	localparam int OP_W   = 2;
	localparam int VTX_W  = 5;
	localparam int CNT_W  = 6;
	localparam int KIND_W = 2;
	localparam int IDX_W  = 1;

	// operation codes of an input word
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_EDGE   = 2'd1;
	localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

	// result kinds
	localparam logic [KIND_W-1:0] KIND_VISIT  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PARENT = 2'd1;
	localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd2;

	// configuration register indexes
	localparam logic [IDX_W-1:0] REG_VERTEX_COUNT  = 1'd0;
	localparam logic [IDX_W-1:0] REG_DIRECTED_MODE = 1'd1;

	// controller to datapath
	typedef struct packed {
		logic              accept;
		logic              clear;
		logic              edge_rd_a;
		logic              edge_wr_a;
		logic              edge_rd_b;
		logic              edge_wr_b;
		logic              init;
		logic              pop;
		logic              visit;
		logic              load_nbr;
		logic              push;
		logic              par_start;
		logic              par_rd;
		logic              par_next;
		logic              emit;
		logic [KIND_W-1:0] kind;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            edge_ok;
		logic            src_ok;
		logic            directed;
		logic            stack_empty;
		logic            nbr_empty;
		logic            u_ok;
		logic            rec_last;
	} status_t;

endpackage

>>> rtl/graph_depth_first_search.sv
// ----------------------------------------------------------------------------
// graph_depth_first_search
// Adjacency-matrix graph store with a stack-based depth-first walk.
// ----------------------------------------------------------------------------
// One input word at a time is taken. A clear acts as it is accepted, an accepted
// edge is a read-modify-write of one adjacency row in directed mode and of two
// otherwise (through the one read and one write port of the row memory), and
// an out-of-range source gives an error result. A search starts with the
// source on the stack; each visited vertex takes a stack pop, a registered
// adjacency row read and one neighbor push per cycle for each newly reached
// neighbor, and once the stack is found empty one parent record per vertex is
// returned through the parent table read port. Results wait in a one-word
// output register, so a new input word is taken while the final result is
// still pending. Adjacency rows are cleared by per-row valid bits, so no
// clearing pass follows reset.
module graph_depth_first_search #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [gdfs_pkg::OP_W-1:0]      op,
	input  logic [gdfs_pkg::VTX_W-1:0]     edge_from,
	input  logic [gdfs_pkg::VTX_W-1:0]     edge_to,
	input  logic [gdfs_pkg::VTX_W-1:0]     source_vertex,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [gdfs_pkg::KIND_W-1:0]    kind,
	output logic [gdfs_pkg::VTX_W-1:0]     vertex,
	output logic [gdfs_pkg::VTX_W-1:0]     parent_vertex,
	output logic                           has_parent,
	output logic                           last,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [gdfs_pkg::IDX_W-1:0]     cfg_index,
	input  logic [gdfs_pkg::CNT_W-1:0]     cfg_data
);

	gdfs_pkg::cmd_t    cmd;
	gdfs_pkg::status_t st;

	logic [gdfs_pkg::CNT_W-1:0]  vertex_count_q;
	logic                        directed_mode_q;
	logic                        out_valid_q;
	logic [gdfs_pkg::KIND_W-1:0] kind_q;
	logic [gdfs_pkg::VTX_W-1:0]  vertex_q;
	logic [gdfs_pkg::VTX_W-1:0]  parent_q;
	logic                        has_parent_q;
	logic                        last_q;
	logic                        can_load;
	logic [gdfs_pkg::KIND_W-1:0] res_kind;
	logic [gdfs_pkg::VTX_W-1:0]  res_vertex;
	logic [gdfs_pkg::VTX_W-1:0]  res_parent;
	logic                        res_has;
	logic                        res_last;

	assign cfg_ready = 1'b1;
	assign can_load  = !out_valid_q || out_ready;

	gdfs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.can_load (can_load),
		.st       (st),
		.cmd      (cmd)
	);

	gdfs_dpath #(
		.MAX_VERTICES (MAX_VERTICES)
	) u_dpath (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.vertex_count  (vertex_count_q),
		.directed_mode (directed_mode_q),
		.op            (op),
		.edge_from     (edge_from),
		.edge_to       (edge_to),
		.source_vertex (source_vertex),
		.res_kind      (res_kind),
		.res_vertex    (res_vertex),
		.res_parent    (res_parent),
		.res_has       (res_has),
		.res_last      (res_last)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_count_q  <= gdfs_pkg::CNT_W'(32);
			directed_mode_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				gdfs_pkg::REG_VERTEX_COUNT:  vertex_count_q  <= cfg_data;
				gdfs_pkg::REG_DIRECTED_MODE: directed_mode_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (out_ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q       <= res_kind;
			vertex_q     <= res_vertex;
			parent_q     <= res_parent;
			has_parent_q <= res_has;
			last_q       <= res_last;
		end
	end

	assign out_valid     = out_valid_q;
	assign kind          = kind_q;
	assign vertex        = vertex_q;
	assign parent_vertex = parent_q;
	assign has_parent    = has_parent_q;
	assign last          = last_q;

	// a result is only produced when the output register can take it
	a_emit_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> can_load)
		else $error("result produced while output register is held");

	// the final result of an item returns the block to input
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && res_last) |=> in_ready)
		else $error("block not ready after final result");

	// pushes only happen with a pending neighbor
	a_push_nbr: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> !st.nbr_empty)
		else $error("push with empty neighbor mask");

	// search and edge work never overlaps input acceptance
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push || cmd.pop || cmd.edge_wr_a || cmd.par_rd) |-> !in_ready)
		else $error("input accepted during ongoing work");

endmodule

>>> rtl/gdfs_ctrl.sv
// ----------------------------------------------------------------------------
// gdfs_ctrl
// Sequencer for graph updates and the depth-first walk: decodes each input
// word, steps the datapath through edge updates, pops, neighbor pushes and
// the final parent-record sweep.
// ----------------------------------------------------------------------------
module gdfs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic              can_load,
	input  gdfs_pkg::status_t st,
	output gdfs_pkg::cmd_t    cmd
);

	localparam logic [3:0] S_IDLE      = 4'd0;
	localparam logic [3:0] S_EDGE_RD_A = 4'd1;
	localparam logic [3:0] S_EDGE_WR_A = 4'd2;
	localparam logic [3:0] S_EDGE_RD_B = 4'd3;
	localparam logic [3:0] S_EDGE_WR_B = 4'd4;
	localparam logic [3:0] S_ERROR     = 4'd5;
	localparam logic [3:0] S_POP       = 4'd6;
	localparam logic [3:0] S_VISIT     = 4'd7;
	localparam logic [3:0] S_NBR       = 4'd8;
	localparam logic [3:0] S_PUSH      = 4'd9;
	localparam logic [3:0] S_PAR_RD    = 4'd10;
	localparam logic [3:0] S_PAR_EMIT  = 4'd11;

	logic [3:0] state_q;
	logic [3:0] state_d;

	assign in_ready = (state_q == S_IDLE);

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.kind = gdfs_pkg::KIND_VISIT;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					case (st.op)
						gdfs_pkg::OP_CLEAR: begin
							cmd.clear = 1'b1;
						end
						gdfs_pkg::OP_EDGE: begin
							if (st.edge_ok) state_d = S_EDGE_RD_A;
						end
						gdfs_pkg::OP_SEARCH: begin
							if (st.src_ok) begin
								cmd.init = 1'b1;
								state_d  = S_POP;
							end else begin
								state_d = S_ERROR;
							end
						end
						default: ;
					endcase
				end
			end
			S_EDGE_RD_A: begin
				cmd.edge_rd_a = 1'b1;
				state_d       = S_EDGE_WR_A;
			end
			S_EDGE_WR_A: begin
				cmd.edge_wr_a = 1'b1;
				state_d       = st.directed ? S_IDLE : S_EDGE_RD_B;
			end
			S_EDGE_RD_B: begin
				cmd.edge_rd_b = 1'b1;
				state_d       = S_EDGE_WR_B;
			end
			S_EDGE_WR_B: begin
				cmd.edge_wr_b = 1'b1;
				state_d       = S_IDLE;
			end
			S_ERROR: begin
				if (can_load) begin
					cmd.emit = 1'b1;
					cmd.kind = gdfs_pkg::KIND_ERROR;
					state_d  = S_IDLE;
				end
			end
			S_POP: begin
				if (st.stack_empty) begin
					cmd.par_start = 1'b1;
					state_d       = S_PAR_RD;
				end else begin
					cmd.pop = 1'b1;
					state_d = S_VISIT;
				end
			end
			S_VISIT: begin
				if (!st.u_ok) begin
					state_d = S_POP;
				end else if (can_load) begin
					cmd.emit  = 1'b1;
					cmd.kind  = gdfs_pkg::KIND_VISIT;
					cmd.visit = 1'b1;
					state_d   = S_NBR;
				end
			end
			S_NBR: begin
				cmd.load_nbr = 1'b1;
				state_d      = S_PUSH;
			end
			S_PUSH: begin
				if (st.nbr_empty) state_d = S_POP;
				else cmd.push = 1'b1;
			end
			S_PAR_RD: begin
				cmd.par_rd = 1'b1;
				state_d    = S_PAR_EMIT;
			end
			S_PAR_EMIT: begin
				if (can_load) begin
					cmd.emit = 1'b1;
					cmd.kind = gdfs_pkg::KIND_PARENT;
					if (st.rec_last) begin
						state_d = S_IDLE;
					end else begin
						cmd.par_next = 1'b1;
						state_d      = S_PAR_RD;
					end
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else state_q <= state_d;
	end

endmodule

>>> rtl/gdfs_dpath.sv
// ----------------------------------------------------------------------------
// gdfs_dpath
// Adjacency rows, visit stack, parent table and color masks of the search,
// plus the result word builder.
// ----------------------------------------------------------------------------
module gdfs_dpath #(
	parameter int MAX_VERTICES = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  gdfs_pkg::cmd_t                cmd,
	output gdfs_pkg::status_t             st,
	input  logic [gdfs_pkg::CNT_W-1:0]    vertex_count,
	input  logic                          directed_mode,
	input  logic [gdfs_pkg::OP_W-1:0]     op,
	input  logic [gdfs_pkg::VTX_W-1:0]    edge_from,
	input  logic [gdfs_pkg::VTX_W-1:0]    edge_to,
	input  logic [gdfs_pkg::VTX_W-1:0]    source_vertex,
	output logic [gdfs_pkg::KIND_W-1:0]   res_kind,
	output logic [gdfs_pkg::VTX_W-1:0]    res_vertex,
	output logic [gdfs_pkg::VTX_W-1:0]    res_parent,
	output logic                          res_has,
	output logic                          res_last
);

	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int SP_W = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] BIT0 = MAX_VERTICES'(1);

	// highest set bit of a neighbor mask
	function automatic logic [IW-1:0] top_bit(input logic [MAX_VERTICES-1:0] m);
		logic [IW-1:0] r;
		r = '0;
		for (int k = 0; k < MAX_VERTICES; k++) begin
			if (m[k]) r = IW'(k);
		end
		return r;
	endfunction

	// storage
	logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
	logic [IW-1:0]           stk_mem [MAX_VERTICES];
	logic [IW-1:0]           par_mem [MAX_VERTICES];

	logic [MAX_VERTICES-1:0] row_vld_q;
	logic [MAX_VERTICES-1:0] white_q;
	logic [MAX_VERTICES-1:0] black_q;
	logic [MAX_VERTICES-1:0] has_q;
	logic [MAX_VERTICES-1:0] nbr_q;
	logic [SP_W-1:0]         sp_q;
	logic [IW-1:0]           rec_q;

	logic [gdfs_pkg::VTX_W-1:0] a_q;
	logic [gdfs_pkg::VTX_W-1:0] b_q;
	logic [gdfs_pkg::VTX_W-1:0] src_q;
	logic [MAX_VERTICES-1:0]    adj_rd_q;
	logic                       rd_vld_q;
	logic [IW-1:0]              stk_rd_q;
	logic [IW-1:0]              par_rd_q;

	logic [gdfs_pkg::CNT_W-1:0] n_eff;
	logic [MAX_VERTICES-1:0]    range_mask;
	logic [MAX_VERTICES-1:0]    row_eff;
	logic [IW-1:0]              rd_row;
	logic [IW-1:0]              wr_row;
	logic [MAX_VERTICES-1:0]    wr_data;
	logic [IW-1:0]              nbr_top;
	logic [SP_W-1:0]            sp_m1;
	logic [IW-1:0]              src_idx;

	// active vertex count, clamped to 1..MAX_VERTICES
	always_comb begin
		if (vertex_count == '0) n_eff = gdfs_pkg::CNT_W'(1);
		else if (vertex_count > gdfs_pkg::CNT_W'(MAX_VERTICES))
			n_eff = gdfs_pkg::CNT_W'(MAX_VERTICES);
		else n_eff = vertex_count;
	end

	always_comb begin
		for (int k = 0; k < MAX_VERTICES; k++) begin
			range_mask[k] = (gdfs_pkg::CNT_W'(k) < n_eff);
		end
	end

	assign src_idx = source_vertex[IW-1:0];
	assign row_eff = rd_vld_q ? adj_rd_q : '0;
	assign nbr_top = top_bit(nbr_q);
	assign sp_m1   = sp_q - SP_W'(1);

	// adjacency port selection
	always_comb begin
		if (cmd.edge_rd_a) rd_row = a_q[IW-1:0];
		else if (cmd.edge_rd_b) rd_row = b_q[IW-1:0];
		else rd_row = stk_rd_q;
	end

	always_comb begin
		if (cmd.edge_wr_a) begin
			wr_row  = a_q[IW-1:0];
			wr_data = row_eff | (BIT0 << b_q[IW-1:0]);
		end else begin
			wr_row  = b_q[IW-1:0];
			wr_data = row_eff | (BIT0 << a_q[IW-1:0]);
		end
	end

	// status back to the controller
	always_comb begin
		st.op          = op;
		st.edge_ok     = (gdfs_pkg::CNT_W'(edge_from) < n_eff) &&
		                 (gdfs_pkg::CNT_W'(edge_to) < n_eff);
		st.src_ok      = (gdfs_pkg::CNT_W'(source_vertex) < n_eff);
		st.directed    = directed_mode;
		st.stack_empty = (sp_q == '0);
		st.nbr_empty   = (nbr_q == '0);
		st.u_ok        = !black_q[stk_rd_q];
		st.rec_last    = ((gdfs_pkg::CNT_W'(rec_q) + gdfs_pkg::CNT_W'(1)) == n_eff);
	end

	// input word capture
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			a_q   <= edge_from;
			b_q   <= edge_to;
			src_q <= source_vertex;
		end
	end

	// adjacency row memory
	always_ff @(posedge clk) begin
		if (cmd.edge_rd_a || cmd.edge_rd_b || cmd.visit) begin
			adj_rd_q <= adj_mem[rd_row];
			rd_vld_q <= row_vld_q[rd_row];
		end
		if (cmd.edge_wr_a || cmd.edge_wr_b) adj_mem[wr_row] <= wr_data;
	end

	// visit stack memory
	always_ff @(posedge clk) begin
		if (cmd.init) stk_mem[0] <= src_idx;
		else if (cmd.push) stk_mem[sp_q[IW-1:0]] <= nbr_top;
		if (cmd.pop) stk_rd_q <= stk_mem[sp_m1[IW-1:0]];
	end

	// parent table memory
	always_ff @(posedge clk) begin
		if (cmd.push) par_mem[nbr_top] <= stk_rd_q;
		if (cmd.par_rd) par_rd_q <= par_mem[rec_q];
	end

	// row valid bits, colors, stack pointer and sweep counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			white_q   <= '0;
			black_q   <= '0;
			has_q     <= '0;
			nbr_q     <= '0;
			sp_q      <= '0;
			rec_q     <= '0;
		end else begin
			if (cmd.clear) row_vld_q <= '0;
			else if (cmd.edge_wr_a || cmd.edge_wr_b) row_vld_q[wr_row] <= 1'b1;

			if (cmd.init) begin
				white_q <= range_mask & ~(BIT0 << src_idx);
				black_q <= '0;
				has_q   <= '0;
				sp_q    <= SP_W'(1);
			end else if (cmd.pop) begin
				sp_q <= sp_m1;
			end else if (cmd.push) begin
				sp_q             <= sp_q + SP_W'(1);
				white_q[nbr_top] <= 1'b0;
				has_q[nbr_top]   <= 1'b1;
				nbr_q[nbr_top]   <= 1'b0;
			end

			if (cmd.visit) black_q[stk_rd_q] <= 1'b1;
			if (cmd.load_nbr) nbr_q <= row_eff & white_q & range_mask;

			if (cmd.par_start) rec_q <= '0;
			else if (cmd.par_next) rec_q <= rec_q + IW'(1);
		end
	end

	// result word
	always_comb begin
		res_kind   = cmd.kind;
		res_vertex = '0;
		res_parent = '0;
		res_has    = 1'b0;
		res_last   = 1'b0;
		case (cmd.kind)
			gdfs_pkg::KIND_VISIT: begin
				res_vertex = gdfs_pkg::VTX_W'(stk_rd_q);
			end
			gdfs_pkg::KIND_PARENT: begin
				res_vertex = gdfs_pkg::VTX_W'(rec_q);
				res_has    = has_q[rec_q];
				res_parent = has_q[rec_q] ? gdfs_pkg::VTX_W'(par_rd_q) : '0;
				res_last   = st.rec_last;
			end
			default: begin
				res_vertex = src_q;
				res_last   = 1'b1;
			end
		endcase
	end

endmodule
